// ----- src/mcc_pkg.sv -----
// shared types, constants and md5 tables for the candidate checker
package mcc_pkg;

   localparam int MaxLength    = 10;
   localparam int AlphabetSize = 36;
   localparam int IndexWidth   = 52;
   localparam int LengthWidth  = 4;
   localparam int DigitWidth   = 6;
   localparam int NumRounds    = 64;
   localparam int RoundWidth   = 6;

   localparam logic [31:0] InitA = 32'h67452301;
   localparam logic [31:0] InitB = 32'hefcdab89;
   localparam logic [31:0] InitC = 32'h98badcfe;
   localparam logic [31:0] InitD = 32'h10325476;

   localparam logic [0:0] CsrTargetLow  = 1'b0;
   localparam logic [0:0] CsrTargetHigh = 1'b1;

   typedef struct packed {
      logic [IndexWidth-1:0]  candidate_index;
      logic [LengthWidth-1:0] candidate_length;
   } req_beat_type;

   typedef struct packed {
      logic                  digest_matches;
      logic [IndexWidth-1:0] checked_index;
   } rsp_beat_type;

   typedef logic [MaxLength-1:0][DigitWidth-1:0] digit_vec_type;

   typedef struct packed {
      logic [IndexWidth-1:0]  index;
      logic [LengthWidth-1:0] length;
      digit_vec_type          digits;
   } radix_work_type;

   typedef struct packed {
      logic [IndexWidth-1:0] index;
      logic [31:0]           a;
      logic [31:0]           b;
      logic [31:0]           c;
      logic [31:0]           d;
      logic [15:0][31:0]     w;
   } md5_work_type;

   function automatic logic [31:0] md5_k(input logic [RoundWidth-1:0] rnd);
      logic [31:0] k;
      case (rnd)
         6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
         6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
         6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
         6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
         6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
         6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
         6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
         6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
         6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
         6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
         6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
         6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
         6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
         6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
         6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
         6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
         6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
         6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
         6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
         6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
         6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
         6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] md5_shift(input logic [RoundWidth-1:0] rnd);
      logic [4:0] s;
      case ({rnd[5:4], rnd[1:0]})
         4'b0000: s = 5'd7;   4'b0001: s = 5'd12;
         4'b0010: s = 5'd17;  4'b0011: s = 5'd22;
         4'b0100: s = 5'd5;   4'b0101: s = 5'd9;
         4'b0110: s = 5'd14;  4'b0111: s = 5'd20;
         4'b1000: s = 5'd4;   4'b1001: s = 5'd11;
         4'b1010: s = 5'd16;  4'b1011: s = 5'd23;
         4'b1100: s = 5'd6;   4'b1101: s = 5'd10;
         4'b1110: s = 5'd15;  4'b1111: s = 5'd21;
         default: s = 5'd7;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] md5_word(input logic [RoundWidth-1:0] rnd);
      logic [3:0] g;
      case (rnd[5:4])
         2'd0:    g = rnd[3:0];
         2'd1:    g = 4'(5 * rnd[3:0] + 1);
         2'd2:    g = 4'(3 * rnd[3:0] + 5);
         2'd3:    g = 4'(7 * rnd[3:0]);
         default: g = rnd[3:0];
      endcase
      return g;
   endfunction

   // digit to alphabet character: A-Z, then 1-9, then 0
   function automatic logic [7:0] digit_char(input logic [DigitWidth-1:0] dig);
      logic [7:0] ch;
      if (dig < 6'd26) begin
         ch = 8'h41 + 8'(dig);
      end else if (dig < 6'd35) begin
         ch = 8'h31 + 8'(dig - 6'd26);
      end else begin
         ch = 8'h30;
      end
      return ch;
   endfunction

endpackage

// ----- src/mcc_radix_cell.sv -----
// one bit of the msb-first binary to base-36 conversion chain
module mcc_radix_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [5:0]                  bit_pos,
   input  logic                        valid_prev,
   input  mcc_pkg::radix_work_type     work_prev,
   output logic                        valid_out,
   output mcc_pkg::radix_work_type     work_out
);
   import mcc_pkg::*;

   logic           valid_ff;
   radix_work_type work_ff;
   radix_work_type work_in;

   // double every digit and add the index bit, carry ripples up
   always_comb begin
      logic             carry;
      logic [DigitWidth:0] t;
      work_in = work_prev;
      carry   = work_prev.index[bit_pos];
      for (int i = 0; i < MaxLength; i++) begin
         t = {work_prev.digits[i], 1'b0} + {{DigitWidth{1'b0}}, carry};
         if (t >= (DigitWidth+1)'(AlphabetSize)) begin
            work_in.digits[i] = DigitWidth'(t - (DigitWidth+1)'(AlphabetSize));
            carry = 1'b1;
         end else begin
            work_in.digits[i] = DigitWidth'(t);
            carry = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_prev;
      end
      work_ff <= work_in;
   end

   assign valid_out = valid_ff;
   assign work_out  = work_ff;

endmodule

// ----- src/mcc_round_cell.sv -----
// one md5 round, registered
module mcc_round_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [5:0]                  round_num,
   input  logic                        valid_prev,
   input  mcc_pkg::md5_work_type       work_prev,
   output logic                        valid_out,
   output mcc_pkg::md5_work_type       work_out
);
   import mcc_pkg::*;

   logic         valid_ff;
   md5_work_type work_ff;
   md5_work_type work_in;

   always_comb begin
      logic [31:0] f;
      logic [31:0] sum;
      logic [31:0] rot;
      logic [4:0]  s;
      case (round_num[5:4])
         2'd0:    f = (work_prev.b & work_prev.c) | (~work_prev.b & work_prev.d);
         2'd1:    f = (work_prev.d & work_prev.b) | (~work_prev.d & work_prev.c);
         2'd2:    f = work_prev.b ^ work_prev.c ^ work_prev.d;
         2'd3:    f = work_prev.c ^ (work_prev.b | ~work_prev.d);
         default: f = '0;
      endcase
      sum = work_prev.a + f + md5_k(round_num) + work_prev.w[md5_word(round_num)];
      s   = md5_shift(round_num);
      rot = (sum << s) | (sum >> (5'd0 - s));
      work_in   = work_prev;
      work_in.a = work_prev.d;
      work_in.d = work_prev.c;
      work_in.c = work_prev.b;
      work_in.b = work_prev.b + rot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_prev;
      end
      work_ff <= work_in;
   end

   assign valid_out = valid_ff;
   assign work_out  = work_ff;

endmodule

// ----- src/md5_candidate_checker.sv -----
// top level: base-36 candidate build, unrolled md5 and digest compare
// pipeline: 52 radix cells, one padding stage, 64 round cells and one compare stage
// throughput: one candidate per cycle, set by the fully unrolled cell chains
// reset: synchronous, clears all stage valid bits and both target registers
// the receiver cannot stall: rsp_valid is a one-cycle strobe, busy stays low
module md5_candidate_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  mcc_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   output mcc_pkg::rsp_beat_type rsp_data,
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [63:0]           csr_wdata
);
   import mcc_pkg::*;

   // configuration registers
   logic [63:0] target_low_ff;
   logic [63:0] target_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_low_ff  <= '0;
         target_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrTargetLow:  target_low_ff  <= csr_wdata;
            CsrTargetHigh: target_high_ff <= csr_wdata;
            default:       ;
         endcase
      end
   end

   // no internal backpressure, every cycle can take a beat
   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // radix chain: cell k folds in index bit 51-k, msb first
   logic           radix_valid [IndexWidth+1];
   radix_work_type radix_work  [IndexWidth+1];

   always_comb begin
      radix_valid[0]       = accept;
      radix_work[0].index  = req_data.candidate_index;
      radix_work[0].length = req_data.candidate_length;
      radix_work[0].digits = '0;
   end

   for (genvar k = 0; k < IndexWidth; k++) begin : g_radix
      mcc_radix_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .bit_pos    (6'(IndexWidth - 1 - k)),
         .valid_prev (radix_valid[k]),
         .work_prev  (radix_work[k]),
         .valid_out  (radix_valid[k+1]),
         .work_out   (radix_work[k+1])
      );
   end

   // padding stage: characters, 0x80 marker and bit length into one block
   logic           pad_valid_ff;
   md5_work_type   pad_work_ff;
   md5_work_type   pad_work_in;

   always_comb begin
      radix_work_type rw;
      logic [LengthWidth-1:0] len;
      logic [7:0] byte_val;
      rw  = radix_work[IndexWidth];
      // long lengths saturate at the digit count
      len = (rw.length > LengthWidth'(MaxLength)) ? LengthWidth'(MaxLength) : rw.length;
      pad_work_in.index = rw.index;
      pad_work_in.a     = InitA;
      pad_work_in.b     = InitB;
      pad_work_in.c     = InitC;
      pad_work_in.d     = InitD;
      pad_work_in.w     = '0;
      for (int i = 0; i <= MaxLength; i++) begin
         if (i < MaxLength && 4'(i) < len) begin
            byte_val = digit_char(rw.digits[i]);
         end else if (4'(i) == len) begin
            byte_val = 8'h80;
         end else begin
            byte_val = 8'h00;
         end
         pad_work_in.w[i/4][8*(i%4) +: 8] = byte_val;
      end
      pad_work_in.w[14] = {25'd0, len, 3'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_valid_ff <= 1'b0;
      end else begin
         pad_valid_ff <= radix_valid[IndexWidth];
      end
      pad_work_ff <= pad_work_in;
   end

   // md5 round chain
   logic         round_valid [NumRounds+1];
   md5_work_type round_work  [NumRounds+1];

   assign round_valid[0] = pad_valid_ff;
   assign round_work[0]  = pad_work_ff;

   for (genvar r = 0; r < NumRounds; r++) begin : g_round
      mcc_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .round_num  (RoundWidth'(r)),
         .valid_prev (round_valid[r]),
         .work_prev  (round_work[r]),
         .valid_out  (round_valid[r+1]),
         .work_out   (round_work[r+1])
      );
   end

   // final add of the initial state and 128-bit compare
   logic         rsp_valid_ff;
   rsp_beat_type rsp_data_ff;
   rsp_beat_type rsp_data_in;

   always_comb begin
      md5_work_type fw;
      logic [63:0]  lo;
      logic [63:0]  hi;
      fw = round_work[NumRounds];
      lo = {fw.b + InitB, fw.a + InitA};
      hi = {fw.d + InitD, fw.c + InitC};
      rsp_data_in.digest_matches = (lo == target_low_ff) && (hi == target_high_ff);
      rsp_data_in.checked_index  = fw.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= round_valid[NumRounds];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // every accepted beat comes out exactly once after the pipeline depth
   a_beat_delivered: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##118 rsp_valid)
      else $error("accepted beat not delivered on time");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 118))
      else $error("result without a matching beat");

   a_index_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.checked_index == $past(req_data.candidate_index, 118))
      else $error("echoed index does not match");

endmodule
